@@ rtl/kps_pkg.sv @@
// shared types, constants and the key map for the matrix keypad scanner
// no dependencies; imported by kps_core and matrix_keypad_scanner_unit
`default_nettype none

package kps_pkg;

   localparam int unsigned ROW_COUNT   = 4;
   localparam int unsigned COL_COUNT   = 4;
   localparam int unsigned TICK_W      = 16;
   localparam int unsigned CODE_W      = 7;
   localparam int unsigned ROW_IDX_W   = $clog2(ROW_COUNT);
   localparam int unsigned COL_IDX_W   = $clog2(COL_COUNT);
   localparam int unsigned CSR_IDX_W   = 2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOUR_COLUMNS   = 2'd2;

   // register reset values
   localparam logic [TICK_W-1:0] SETTLE_RESET   = 16'd10;
   localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 16'd20;

   // ascii codes of the symbol keys
   localparam logic [CODE_W-1:0] CODE_STAR = 7'd42;
   localparam logic [CODE_W-1:0] CODE_HASH = 7'd35;
   localparam logic [CODE_W-1:0] CODE_A    = 7'd65;
   localparam logic [CODE_W-1:0] CODE_B    = 7'd66;
   localparam logic [CODE_W-1:0] CODE_C    = 7'd67;
   localparam logic [CODE_W-1:0] CODE_D    = 7'd68;

   // one configuration write transaction
   typedef struct packed {
      logic                 valid;
      logic [CSR_IDX_W-1:0] index;
      logic [TICK_W-1:0]    data;
   } kps_csr_type;

   // one result transaction
   typedef struct packed {
      logic [ROW_COUNT-1:0] row_drive;
      logic                 key_valid;
      logic [CODE_W-1:0]    key_code;
      logic                 key_hit;
   } kps_result_type;

   // key position to key code
   function automatic logic [CODE_W-1:0] key_map(input logic [ROW_IDX_W-1:0] row,
                                                 input logic [COL_IDX_W-1:0] col);
      logic [CODE_W-1:0] code;
      unique case ({row, col})
         4'h0: code = 7'd7;
         4'h1: code = 7'd8;
         4'h2: code = 7'd9;
         4'h3: code = CODE_A;
         4'h4: code = 7'd4;
         4'h5: code = 7'd5;
         4'h6: code = 7'd6;
         4'h7: code = CODE_B;
         4'h8: code = 7'd1;
         4'h9: code = 7'd2;
         4'hA: code = 7'd3;
         4'hB: code = CODE_C;
         4'hC: code = CODE_STAR;
         4'hD: code = 7'd0;
         4'hE: code = CODE_HASH;
         4'hF: code = CODE_D;
         default: code = 7'd0;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

@@ rtl/kps_core.sv @@
// scan sequencer: configuration registers, scan state machine, result logic
// depends on kps_pkg
`default_nettype none

module kps_core
   import kps_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [COL_COUNT-1:0] column_lines,
   input  wire kps_csr_type          csr,
   output kps_result_type            result
);

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_SETTLE   = 3'd1,
      PH_DEBOUNCE = 3'd2,
      PH_SCAN     = 3'd3,
      PH_RELEASE  = 3'd4
   } phase_type;

   logic [TICK_W-1:0]    settle_ff;
   logic [TICK_W-1:0]    debounce_ff;
   logic                 four_columns_ff;

   phase_type            phase_ff, phase_in;
   logic [TICK_W-1:0]    wait_ff, wait_in;
   logic [ROW_IDX_W-1:0] row_ff, row_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic                 hit_ff, hit_in;

   logic [COL_COUNT-1:0] col_mask;
   logic [COL_COUNT-1:0] pressed;
   logic [TICK_W-1:0]    wait_inc;
   logic                 col_found;
   logic [COL_IDX_W-1:0] col_sel;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff       <= SETTLE_RESET;
         debounce_ff     <= DEBOUNCE_RESET;
         four_columns_ff <= 1'b1;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_SETTLE_TICKS:   settle_ff       <= csr.data;
            CSR_DEBOUNCE_TICKS: debounce_ff     <= csr.data;
            CSR_FOUR_COLUMNS:   four_columns_ff <= csr.data[0];
            default: ;
         endcase
      end
   end

   // active-high pressed columns, column 3 masked on a 4x3 keypad
   assign col_mask = four_columns_ff ? 4'hF : 4'h7;
   assign pressed  = ~column_lines & col_mask;

   // saturating tick counter increment
   assign wait_inc = (wait_ff != '1) ? wait_ff + 1'b1 : wait_ff;

   // lowest pressed column
   always_comb begin
      col_found = 1'b0;
      col_sel   = '0;
      for (int c = COL_COUNT - 1; c >= 0; c--) begin
         if (pressed[c]) begin
            col_found = 1'b1;
            col_sel   = COL_IDX_W'(c);
         end
      end
   end

   // next state and this tick's result
   always_comb begin
      phase_in = phase_ff;
      wait_in  = wait_ff;
      row_in   = row_ff;
      code_in  = code_ff;
      hit_in   = hit_ff;
      result   = '0;
      result.row_drive = '0;
      unique case (phase_ff)
         PH_SETTLE: begin
            wait_in = wait_inc;
            if (wait_inc >= settle_ff) begin
               phase_in = PH_DEBOUNCE;
               wait_in  = '0;
            end
         end
         PH_DEBOUNCE: begin
            wait_in = wait_inc;
            if (wait_inc >= debounce_ff) begin
               wait_in = '0;
               if (pressed != '0) begin
                  phase_in = PH_SCAN;
                  row_in   = '0;
                  code_in  = '0;
                  hit_in   = 1'b0;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_SCAN: begin
            result.row_drive = ~(ROW_COUNT'(1) << row_ff);
            wait_in = wait_inc;
            if (wait_inc >= settle_ff) begin
               wait_in = '0;
               if (col_found) begin
                  code_in = key_map(row_ff, col_sel);
                  hit_in  = 1'b1;
               end
               if (row_ff == ROW_IDX_W'(ROW_COUNT - 1)) begin
                  row_in   = '0;
                  phase_in = PH_RELEASE;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         PH_RELEASE: begin
            wait_in = wait_inc;
            if (wait_inc >= settle_ff) begin
               wait_in = '0;
               if (pressed == '0) begin
                  result.key_valid = 1'b1;
                  result.key_code  = code_ff;
                  result.key_hit   = hit_ff;
                  phase_in         = PH_IDLE;
               end
            end
         end
         default: begin
            // idle, and any unused code behaves as idle
            phase_in = PH_IDLE;
            if (pressed != '0) begin
               phase_in = PH_SETTLE;
               wait_in  = '0;
            end
         end
      endcase
   end

   // scan state, advanced once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wait_ff  <= '0;
         row_ff   <= '0;
         code_ff  <= '0;
         hit_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         row_ff   <= row_in;
         code_ff  <= code_in;
         hit_ff   <= hit_in;
      end
   end

   // row pointer only moves inside a scan
   a_row_outside_scan: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_SCAN |-> row_ff == '0)
      else $error("row index not zero outside scan");

   // no press keeps the block idle
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_IDLE && pressed == '0 |=> phase_ff == PH_IDLE)
      else $error("left idle without a press");

   // a report ends the key cycle
   a_report_to_idle: assert property (@(posedge clock) disable iff (reset)
      step && result.key_valid |=> phase_ff == PH_IDLE)
      else $error("report did not return to idle");

endmodule

`default_nettype wire

@@ rtl/matrix_keypad_scanner_unit.sv @@
// top level of the matrix keypad scanner: handshakes and the result register
// depends on kps_pkg and kps_core
`default_nettype none

// Matrix keypad scanner for a 4-row keypad with 3 or 4 columns. Each request
// transaction is one timebase tick carrying the sampled active-low column
// lines; each one yields exactly one response transaction holding the row
// drive in effect for that sample, plus a key report (valid, code, hit) on
// the tick a released key is confirmed. One tick is taken per clock cycle:
// the scan state machine advances in the accepting cycle and the response
// sits in a single output register, so a new tick is accepted every cycle
// while the response side keeps up. Settle and debounce times are counted
// in ticks and set through the csr port (index 0 settle, 1 debounce,
// 2 four-column select); write them only while the block is idle.
module matrix_keypad_scanner_unit
   import kps_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [COL_COUNT-1:0] req_column_lines,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [ROW_COUNT-1:0] rsp_row_drive,
   output      logic                 rsp_key_valid,
   output      logic [CODE_W-1:0]    rsp_key_code,
   output      logic                 rsp_key_hit,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TICK_W-1:0]    csr_wdata
);

   logic           req_accept;
   kps_csr_type    csr_write;
   kps_result_type result;
   kps_result_type rsp_ff;
   logic           rsp_valid_ff;

   // handshakes
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign csr_write.valid = csr_valid;
   assign csr_write.index = csr_index;
   assign csr_write.data  = csr_wdata;

   kps_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (req_accept),
      .column_lines (req_column_lines),
      .csr          (csr_write),
      .result       (result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_drive = rsp_ff.row_drive;
   assign rsp_key_valid = rsp_ff.key_valid;
   assign rsp_key_code  = rsp_ff.key_code;
   assign rsp_key_hit   = rsp_ff.key_hit;

   // every accepted tick shows up as a response next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted transaction produced no response");

   // hit and code are only reported with a key
   a_hit_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_key_valid |-> !rsp_key_hit && rsp_key_code == '0)
      else $error("key fields set without a report");

   // a stalled response stays put
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({rsp_row_drive, rsp_key_valid, rsp_key_code, rsp_key_hit}))
      else $error("stalled response changed");

endmodule

`default_nettype wire
